// ===== sv/rwcp_pkg.sv =====
package rwcp_pkg;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_FMT_READY = 3'd1,
    KIND_DATA_START = 3'd2,
    KIND_NOT_WAVE  = 3'd3,
    KIND_BAD_ALIGN = 3'd4,
    KIND_END       = 3'd5
  } kind_e;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam int unsigned FmtBytes = 16;
  localparam int unsigned FmtW     = FmtBytes * 8;

  // bit offsets of the captured format block, little endian
  localparam int unsigned FMT_TAG_LSB   = 0;
  localparam int unsigned FMT_CHAN_LSB  = 16;
  localparam int unsigned FMT_RATE_LSB  = 32;
  localparam int unsigned FMT_BRATE_LSB = 64;
  localparam int unsigned FMT_ALIGN_LSB = 96;
  localparam int unsigned FMT_BITS_LSB  = 112;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        data_byte;
    logic              last;
    logic              eor;
    logic [FmtW-1:0]   fmt;
    logic [31:0]       size;
  } entry_t;

endpackage

// ===== sv/rwcp_front.sv =====
module rwcp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic              sos_i,
  output logic              push_o,
  output rwcp_pkg::entry_t  entry_o
);

  localparam logic [2:0] PH_RIFF = 3'd0;
  localparam logic [2:0] PH_CHDR = 3'd1;
  localparam logic [2:0] PH_FMT  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_SKIP = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  logic [2:0]                  phase_q, phase_d, cur_phase;
  logic [4:0]                  hp_q, hp_d, cur_hp;
  logic [31:0]                 tag_q, tag_d, cur_tag;
  logic [31:0]                 size_q, size_d, cur_size;
  logic [31:0]                 chunk_q, chunk_d, cur_chunk;
  logic [31:0]                 riff_q, riff_d, cur_riff;
  logic [rwcp_pkg::FmtW-1:0]   fmt_q, fmt_d, cur_fmt;
  logic                        fv_q, fv_d, cur_fv;

  logic                        has_res;
  rwcp_pkg::kind_e             kind;
  logic [7:0]                  dbyte;
  logic                        last, eor, boundary;
  logic [31:0]                 div_size;
  logic [15:0]                 align;

  always_comb begin
    cur_phase = sos_i ? PH_RIFF : phase_q;
    cur_hp    = sos_i ? '0 : hp_q;
    cur_tag   = sos_i ? '0 : tag_q;
    cur_size  = sos_i ? '0 : size_q;
    cur_chunk = sos_i ? '0 : chunk_q;
    cur_riff  = sos_i ? '0 : riff_q;
    cur_fmt   = sos_i ? '0 : fmt_q;
    cur_fv    = sos_i ? 1'b0 : fv_q;
  end

  assign align = cur_fmt[rwcp_pkg::FMT_ALIGN_LSB +: 16];

  always_comb begin
    phase_d  = cur_phase;
    hp_d     = cur_hp;
    tag_d    = cur_tag;
    size_d   = cur_size;
    chunk_d  = cur_chunk;
    riff_d   = cur_riff;
    fmt_d    = cur_fmt;
    fv_d     = cur_fv;
    has_res  = 1'b0;
    kind     = rwcp_pkg::KIND_DATA;
    dbyte    = '0;
    last     = 1'b0;
    eor      = 1'b0;
    boundary = 1'b0;
    div_size = '0;

    if (cur_phase == PH_RIFF) begin
      if (cur_hp < 5'd4 || cur_hp >= 5'd8) begin
        tag_d = {byte_i, cur_tag[31:8]};
      end else begin
        size_d = {byte_i, cur_size[31:8]};
      end
      hp_d = cur_hp + 5'd1;
      if (hp_d == 5'd4 && tag_d != rwcp_pkg::TAG_RIFF) begin
        has_res = 1'b1;
        kind    = rwcp_pkg::KIND_NOT_WAVE;
        phase_d = PH_DONE;
      end else if (hp_d >= 5'd12) begin
        hp_d = '0;
        if (tag_d != rwcp_pkg::TAG_WAVE) begin
          has_res = 1'b1;
          kind    = rwcp_pkg::KIND_NOT_WAVE;
          phase_d = PH_DONE;
        end else begin
          riff_d = (size_d >= 32'd4) ? size_d - 32'd4 : '0;
          if (riff_d == '0) begin
            has_res = 1'b1;
            kind    = rwcp_pkg::KIND_END;
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_CHDR;
          end
        end
      end
    end else if (cur_phase != PH_DONE) begin
      if (cur_riff != '0) begin
        riff_d = cur_riff - 32'd1;
        eor    = (riff_d == '0);
      end
      if (cur_phase == PH_CHDR) begin
        if (cur_hp < 5'd4) begin
          tag_d = {byte_i, cur_tag[31:8]};
        end else begin
          size_d = {byte_i, cur_size[31:8]};
        end
        hp_d = cur_hp + 5'd1;
        if (hp_d >= 5'd8) begin
          hp_d    = '0;
          chunk_d = size_d;
          if (tag_d == rwcp_pkg::TAG_FMT) begin
            fv_d    = 1'b0;
            phase_d = PH_FMT;
          end else if (tag_d == rwcp_pkg::TAG_DATA) begin
            has_res = 1'b1;
            if (cur_fv && align != '0) begin
              kind     = rwcp_pkg::KIND_DATA_START;
              div_size = size_d;
            end else begin
              kind = rwcp_pkg::KIND_BAD_ALIGN;
            end
            phase_d = PH_DATA;
          end else begin
            phase_d = PH_SKIP;
          end
          boundary = (size_d == '0);
        end
      end else begin
        if (cur_phase == PH_FMT && cur_hp < 5'd16) begin
          fmt_d[{cur_hp[3:0], 3'b000} +: 8] = byte_i;
          hp_d = cur_hp + 5'd1;
          if (hp_d == 5'd16) begin
            fv_d    = 1'b1;
            has_res = 1'b1;
            kind    = rwcp_pkg::KIND_FMT_READY;
          end
        end else if (cur_phase == PH_DATA) begin
          has_res = 1'b1;
          kind    = rwcp_pkg::KIND_DATA;
          dbyte   = byte_i;
        end
        chunk_d = cur_chunk - 32'd1;
        if (chunk_d == '0) begin
          last     = (cur_phase == PH_DATA);
          boundary = 1'b1;
        end
      end
      if (boundary) begin
        hp_d = '0;
        if (riff_d == '0) begin
          phase_d = PH_DONE;
          if (!has_res) begin
            has_res = 1'b1;
            kind    = rwcp_pkg::KIND_END;
          end
        end else begin
          phase_d = PH_CHDR;
        end
      end
    end
    if (kind == rwcp_pkg::KIND_END) begin
      eor = 1'b1;
    end
  end

  assign push_o            = accept_i && has_res;
  assign entry_o.kind      = kind;
  assign entry_o.data_byte = dbyte;
  assign entry_o.last      = last;
  assign entry_o.eor       = eor;
  assign entry_o.fmt       = fmt_d;
  assign entry_o.size      = div_size;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      hp_q    <= '0;
      tag_q   <= '0;
      size_q  <= '0;
      chunk_q <= '0;
      riff_q  <= '0;
      fmt_q   <= '0;
      fv_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      hp_q    <= hp_d;
      tag_q   <= tag_d;
      size_q  <= size_d;
      chunk_q <= chunk_d;
      riff_q  <= riff_d;
      fmt_q   <= fmt_d;
      fv_q    <= fv_d;
    end
  end

endmodule

// ===== sv/rwcp_queue.sv =====
module rwcp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rwcp_pkg::entry_t  push_entry_i,
  input  logic              pop_i,
  output rwcp_pkg::entry_t  head_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  rwcp_pkg::entry_t  mem_q [DEPTH];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/rwcp_back.sv =====
module rwcp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rwcp_pkg::entry_t           head_i,
  input  logic                       empty_i,
  output logic                       pop_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output rwcp_pkg::kind_e            kind_o,
  output logic [7:0]                 data_byte_o,
  output logic                       last_o,
  output logic                       eor_o,
  output logic [rwcp_pkg::FmtW-1:0]  fmt_o,
  output logic [31:0]                frames_o
);

  logic              busy_q, busy_d;
  logic              fin_q, fin_d;
  logic [4:0]        cnt_q;
  logic [15:0]       rem_q;
  logic [31:0]       quo_q;
  rwcp_pkg::entry_t  held_q;
  logic              m_valid_q, m_valid_d;
  rwcp_pkg::kind_e   kind_q;
  logic [7:0]        byte_q;
  logic              last_q, eor_q;
  logic [rwcp_pkg::FmtW-1:0] fmt_q;
  logic [31:0]       frames_q;

  logic              out_free, head_start, load_direct, load_div;
  logic [15:0]       divisor;
  logic [16:0]       trial, diff;
  logic              ge;

  assign out_free    = !m_valid_q || m_ready_i;
  assign head_start  = (head_i.kind == rwcp_pkg::KIND_DATA_START);
  assign pop_o       = !empty_i && !busy_q && !fin_q && (head_start || out_free);
  assign load_direct = pop_o && !head_start;
  assign load_div    = fin_q && out_free;
  assign m_valid_d   = load_direct || load_div || (m_valid_q && !m_ready_i);

  assign divisor = held_q.fmt[rwcp_pkg::FMT_ALIGN_LSB +: 16];
  assign trial   = {rem_q, quo_q[31]};
  assign diff    = trial - {1'b0, divisor};
  assign ge      = (trial >= {1'b0, divisor});

  always_comb begin
    busy_d = busy_q;
    fin_d  = fin_q;
    if (pop_o && head_start) begin
      busy_d = 1'b1;
    end else if (busy_q && cnt_q == '0) begin
      busy_d = 1'b0;
      fin_d  = 1'b1;
    end else if (load_div) begin
      fin_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      fin_q     <= 1'b0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      fin_q     <= fin_d;
      m_valid_q <= m_valid_d;
      if (pop_o && head_start) begin
        cnt_q <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_start) begin
      held_q <= head_i;
      quo_q  <= head_i.size;
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[15:0] : trial[15:0];
      quo_q <= {quo_q[30:0], ge};
    end
    if (load_div) begin
      kind_q   <= held_q.kind;
      byte_q   <= held_q.data_byte;
      last_q   <= held_q.last;
      eor_q    <= held_q.eor;
      fmt_q    <= held_q.fmt;
      frames_q <= quo_q;
    end else if (load_direct) begin
      kind_q   <= head_i.kind;
      byte_q   <= head_i.data_byte;
      last_q   <= head_i.last;
      eor_q    <= head_i.eor;
      fmt_q    <= head_i.fmt;
      frames_q <= '0;
    end
  end

  assign m_valid_o   = m_valid_q;
  assign kind_o      = kind_q;
  assign data_byte_o = byte_q;
  assign last_o      = last_q;
  assign eor_o       = eor_q;
  assign fmt_o       = fmt_q;
  assign frames_o    = frames_q;

`ifndef SYNTHESIS
  a_busy_fin_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && fin_q)) else $error("divider busy and finished at once");
  a_busy_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q != '0 |=> busy_q) else $error("divider stopped early");
  a_start_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && kind_q == rwcp_pkg::KIND_DATA_START |->
    fmt_q[rwcp_pkg::FMT_ALIGN_LSB +: 16] != '0) else $error("data start with zero align");
  a_frames_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && kind_q != rwcp_pkg::KIND_DATA_START |-> frames_q == '0)
    else $error("frame count outside data start");
  a_fin_waits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q && !out_free |=> fin_q) else $error("quotient lost while output stalled");
`endif

endmodule

// ===== sv/riff_wave_chunk_parser_unit.sv =====
// Byte-serial RIFF/WAVE parser. One file byte enters per transaction on the
// slave stream (tuser marks the first byte of a new file and restarts parsing);
// results leave on the master stream, kind in tuser, tlast on the final byte of
// each data chunk. A front stage parses one byte per cycle while the queue has
// room and queues results in a QUEUE_DEPTH-entry buffer; a back stage drains
// it into a registered output. Steady throughput is one byte per cycle when
// nothing stalls. A valid data chunk header holds the back stage while the
// one-bit-per-cycle 32-bit by 16-bit divider finds frame_count; the queue takes
// later results until full, then the front stalls until the quotient leaves.
module riff_wave_chunk_parser_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // in_byte
  input  logic [0:0]   s_axis_tuser,   // start_of_stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // data_byte, end_of_riff, format_tag, channels, sample_rate, byte_rate,
  // block_align, bits_per_sample, frame_count, zero fill
  output logic [175:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // kind
  output logic         m_axis_tlast    // last_in_chunk
);

  logic                       accept, push, pop, empty, full;
  rwcp_pkg::entry_t           push_entry, head;
  rwcp_pkg::kind_e            kind;
  logic [7:0]                 data_byte;
  logic                       last, eor;
  logic [rwcp_pkg::FmtW-1:0]  fmt;
  logic [31:0]                frames;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  rwcp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .sos_i    (s_axis_tuser[0]),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  rwcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (empty),
    .full_o       (full)
  );

  rwcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .kind_o      (kind),
    .data_byte_o (data_byte),
    .last_o      (last),
    .eor_o       (eor),
    .fmt_o       (fmt),
    .frames_o    (frames)
  );

  assign m_axis_tuser = kind;
  assign m_axis_tlast = last;
  assign m_axis_tdata = {
    7'd0,
    frames,
    fmt[rwcp_pkg::FMT_BITS_LSB  +: 16],
    fmt[rwcp_pkg::FMT_ALIGN_LSB +: 16],
    fmt[rwcp_pkg::FMT_BRATE_LSB +: 32],
    fmt[rwcp_pkg::FMT_RATE_LSB  +: 32],
    fmt[rwcp_pkg::FMT_CHAN_LSB  +: 16],
    fmt[rwcp_pkg::FMT_TAG_LSB   +: 16],
    eor,
    data_byte
  };

endmodule

// ===== tb/sv/riff_wave_chunk_parser_checker.sv =====
`timescale 1ns / 100ps
module riff_wave_chunk_parser_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // in_byte
  input  logic [0:0]   s_axis_tuser,   // start_of_stream
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // data_byte, end_of_riff, format_tag, channels, sample_rate, byte_rate,
  // block_align, bits_per_sample, frame_count, zero fill
  input  logic [175:0] m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,   // kind
  input  logic         m_axis_tlast,   // last_in_chunk
  output int           fail_cnt_o,
  output int           pending_o
);

  typedef enum logic [2:0] {
    WALK_RIFF,
    WALK_HDR,
    WALK_FMT,
    WALK_DATA,
    WALK_SKIP,
    WALK_DONE
  } walk_e;

  typedef struct {
    rwcp_pkg::kind_e kind;
    logic [7:0]  data_byte;
    logic        last;
    logic        eor;
    logic [15:0] fmt_tag;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [31:0] brate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] frames;
  } wave_result_t;

  wave_result_t expected_q[$];

  walk_e        walk;
  logic [4:0]   hdr_pos;
  logic [31:0]  tag_sr;
  logic [31:0]  size_sr;
  logic [31:0]  chunk_left;
  logic [31:0]  budget;
  logic [127:0] fmt_blk;
  logic         fmt_ok;

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
  end

  task automatic clear_walk();
    walk       = WALK_RIFF;
    hdr_pos    = '0;
    tag_sr     = '0;
    size_sr    = '0;
    chunk_left = '0;
    budget     = '0;
    fmt_blk    = '0;
    fmt_ok     = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic sos);
    wave_result_t    r;
    rwcp_pkg::kind_e k;
    logic            emit;
    logic [7:0]      dbyte;
    logic            last;
    logic            eor;
    logic            boundary;
    logic [31:0]     frames;
    k        = rwcp_pkg::KIND_DATA;
    emit     = 1'b0;
    dbyte    = '0;
    last     = 1'b0;
    eor      = 1'b0;
    boundary = 1'b0;
    frames   = '0;
    if (sos) clear_walk();
    if (walk == WALK_RIFF) begin
      if (hdr_pos < 4 || hdr_pos >= 8) tag_sr = {b, tag_sr[31:8]};
      else size_sr = {b, size_sr[31:8]};
      hdr_pos++;
      if (hdr_pos == 4 && tag_sr != rwcp_pkg::TAG_RIFF) begin
        emit = 1'b1;
        k    = rwcp_pkg::KIND_NOT_WAVE;
        walk = WALK_DONE;
      end else if (hdr_pos >= 12) begin
        hdr_pos = '0;
        if (tag_sr != rwcp_pkg::TAG_WAVE) begin
          emit = 1'b1;
          k    = rwcp_pkg::KIND_NOT_WAVE;
          walk = WALK_DONE;
        end else begin
          budget = (size_sr >= 4) ? size_sr - 32'd4 : '0;
          if (budget == 0) begin
            emit = 1'b1;
            k    = rwcp_pkg::KIND_END;
            walk = WALK_DONE;
          end else begin
            walk = WALK_HDR;
          end
        end
      end
    end else if (walk != WALK_DONE) begin
      if (budget != 0) begin
        budget--;
        if (budget == 0) eor = 1'b1;
      end
      if (walk == WALK_HDR) begin
        if (hdr_pos < 4) tag_sr = {b, tag_sr[31:8]};
        else size_sr = {b, size_sr[31:8]};
        hdr_pos++;
        if (hdr_pos >= 8) begin
          hdr_pos    = '0;
          chunk_left = size_sr;
          if (tag_sr == rwcp_pkg::TAG_FMT) begin
            fmt_ok = 1'b0;
            walk   = WALK_FMT;
          end else if (tag_sr == rwcp_pkg::TAG_DATA) begin
            emit = 1'b1;
            if (fmt_ok && fmt_blk[111:96] != 0) begin
              k      = rwcp_pkg::KIND_DATA_START;
              frames = size_sr / fmt_blk[111:96];
            end else begin
              k = rwcp_pkg::KIND_BAD_ALIGN;
            end
            walk = WALK_DATA;
          end else begin
            walk = WALK_SKIP;
          end
          if (chunk_left == 0) boundary = 1'b1;
        end
      end else begin
        if (walk == WALK_FMT && hdr_pos < 16) begin
          fmt_blk[hdr_pos*8 +: 8] = b;
          hdr_pos++;
          if (hdr_pos == 16) begin
            fmt_ok = 1'b1;
            emit   = 1'b1;
            k      = rwcp_pkg::KIND_FMT_READY;
          end
        end else if (walk == WALK_DATA) begin
          emit  = 1'b1;
          k     = rwcp_pkg::KIND_DATA;
          dbyte = b;
        end
        chunk_left--;
        if (chunk_left == 0) begin
          if (walk == WALK_DATA) last = 1'b1;
          boundary = 1'b1;
        end
      end
      if (boundary) begin
        hdr_pos = '0;
        if (budget == 0) begin
          walk = WALK_DONE;
          if (!emit) begin
            emit = 1'b1;
            k    = rwcp_pkg::KIND_END;
          end
        end else begin
          walk = WALK_HDR;
        end
      end
    end
    if (emit) begin
      r.kind      = k;
      r.data_byte = dbyte;
      r.last      = last;
      r.eor       = eor || (k == rwcp_pkg::KIND_END);
      r.fmt_tag   = fmt_blk[15:0];
      r.chans     = fmt_blk[31:16];
      r.rate      = fmt_blk[63:32];
      r.brate     = fmt_blk[95:64];
      r.align     = fmt_blk[111:96];
      r.bits      = fmt_blk[127:112];
      r.frames    = frames;
      expected_q.push_back(r);
    end
  endtask

  function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_result();
    wave_result_t e;
    if (expected_q.size() == 0) begin
      $error("result with no expectation: kind %0d", m_axis_tuser);
      fail_cnt_o++;
    end else begin
      e = expected_q.pop_front();
      fail_cnt_o += field_mismatch("kind", e.kind, m_axis_tuser);
      fail_cnt_o += field_mismatch("data_byte", e.data_byte, m_axis_tdata[7:0]);
      fail_cnt_o += field_mismatch("last_in_chunk", e.last, m_axis_tlast);
      fail_cnt_o += field_mismatch("end_of_riff", e.eor, m_axis_tdata[8]);
      fail_cnt_o += field_mismatch("format_tag", e.fmt_tag, m_axis_tdata[24:9]);
      fail_cnt_o += field_mismatch("channels", e.chans, m_axis_tdata[40:25]);
      fail_cnt_o += field_mismatch("sample_rate", e.rate, m_axis_tdata[72:41]);
      fail_cnt_o += field_mismatch("byte_rate", e.brate, m_axis_tdata[104:73]);
      fail_cnt_o += field_mismatch("block_align", e.align, m_axis_tdata[120:105]);
      fail_cnt_o += field_mismatch("bits_per_sample", e.bits, m_axis_tdata[136:121]);
      fail_cnt_o += field_mismatch("frame_count", e.frames, m_axis_tdata[168:137]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_walk();
      expected_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tuser[0]);
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== tb/sv/tb_riff_wave_chunk_parser_unit.sv =====
`timescale 1ns / 100ps
module tb_riff_wave_chunk_parser_unit;

  localparam int unsigned ByteTarget = 1900;
  localparam int unsigned StallLimit = 5000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [175:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;

  int          fail_cnt;
  int          pending_cnt;
  int unsigned bytes_sent = 0;
  int unsigned stall_cycles = 0;
  logic [7:0]  wav_q[$];

  riff_wave_chunk_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  riff_wave_chunk_parser_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending_cnt)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic push_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) wav_q.push_back(v[i*8 +: 8]);
  endtask

  task automatic put_le32_at(input int idx, input logic [31:0] v);
    for (int i = 0; i < 4; i++) wav_q[idx + i] = v[i*8 +: 8];
  endtask

  task automatic build_wave();
    logic [127:0] fmt_bits;
    logic [31:0]  csize;
    logic [31:0]  rsize;
    int           n_chunks;
    int           pick;
    int           keep;
    int           body_len;
    int           idx;
    bit           cut;
    wav_q.delete();
    repeat (12) wav_q.push_back(8'h00);
    n_chunks = $urandom_range(1, 4);
    cut = 1'b0;
    for (int c = 0; c < n_chunks && !cut; c++) begin
      pick = (c == 0 && $urandom_range(99) < 80) ? 0 : $urandom_range(0, 9);
      if (pick < 3) begin
        pick = $urandom_range(99);
        csize = (pick < 70) ? 32'd16 :
                (pick < 85) ? 32'(16 + $urandom_range(1, 4)) : 32'($urandom_range(0, 15));
        fmt_bits = {$urandom, $urandom, $urandom, $urandom};
        pick = $urandom_range(9);
        fmt_bits[111:96] = (pick == 0) ? 16'd0 :
                           (pick < 7) ? 16'($urandom_range(1, 4)) : 16'($urandom);
        push_le32(rwcp_pkg::TAG_FMT);
        push_le32(csize);
        for (int i = 0; i < csize; i++) begin
          wav_q.push_back(i < 16 ? fmt_bits[i*8 +: 8] : 8'($urandom));
        end
      end else if (pick < 8) begin
        if ($urandom_range(99) < 85) begin
          csize = $urandom_range(0, 24);
          keep = csize;
        end else begin
          csize = $urandom;
          keep = $urandom_range(0, 8);
          cut = 1'b1;
        end
        push_le32(rwcp_pkg::TAG_DATA);
        push_le32(csize);
        repeat (keep) wav_q.push_back(8'($urandom));
      end else begin
        pick = $urandom_range(3);
        push_le32(pick == 0 ? rwcp_pkg::TAG_FMT ^ (32'h1 << $urandom_range(31)) :
                  pick == 1 ? rwcp_pkg::TAG_DATA ^ (32'h1 << $urandom_range(31)) :
                  32'($urandom));
        csize = $urandom_range(0, 6);
        push_le32(csize);
        repeat (csize) wav_q.push_back(8'($urandom));
      end
    end
    body_len = wav_q.size() - 12;
    pick = $urandom_range(99);
    if (pick < 65) rsize = body_len + 4;
    else if (pick < 77) rsize = $urandom_range(4, body_len + 3);
    else if (pick < 87) rsize = body_len + 4 + $urandom_range(1, 20);
    else if (pick < 95) rsize = $urandom_range(0, 4);
    else rsize = 32'hFFFF_FFFF;
    put_le32_at(0, rwcp_pkg::TAG_RIFF);
    put_le32_at(4, rsize);
    put_le32_at(8, rwcp_pkg::TAG_WAVE);
    pick = $urandom_range(99);
    if (pick < 8) begin
      idx = (pick < 4) ? $urandom_range(0, 3) : $urandom_range(8, 11);
      wav_q[idx] = wav_q[idx] ^ 8'(1 << $urandom_range(7));
    end
    if ($urandom_range(99) < 20) repeat ($urandom_range(1, 4)) wav_q.push_back(8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic sos);
    while (!(bytes_sent >= 200 && bytes_sent < 500) && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= sos;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_file(input logic sos_first);
    for (int i = 0; i < wav_q.size(); i++) send_byte(wav_q[i], i == 0 ? sos_first : 1'b0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    wav_q.delete();
    push_le32(rwcp_pkg::TAG_RIFF ^ 32'h0100_0000);
    send_file(1'b1);
    wav_q.delete();
    push_le32(rwcp_pkg::TAG_RIFF);
    push_le32(32'd2);
    push_le32(rwcp_pkg::TAG_WAVE);
    send_file(1'b1);
    wav_q.delete();
    push_le32(rwcp_pkg::TAG_RIFF);
    push_le32(32'd100);
    push_le32(rwcp_pkg::TAG_WAVE ^ 32'h8000_0000);
    send_file(1'b1);
    while (bytes_sent < ByteTarget) begin
      if ($urandom_range(99) < 6) begin
        wav_q.delete();
        repeat ($urandom_range(1, 20)) wav_q.push_back(8'($urandom));
        send_file(1'($urandom_range(1)));
      end else begin
        build_wave();
        send_file(1'b1);
      end
    end
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (64) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("** riff_wave_chunk_parser_unit: PASSED **");
    end else begin
      $display("** riff_wave_chunk_parser_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && bytes_sent >= 900) begin
        held = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (bytes_sent >= 1300 && bytes_sent < 1600) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 23);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
        $display("** riff_wave_chunk_parser_unit: FAILED **");
        $finish;
      end
    end
  end

endmodule
